/* sv/led_cross_fade_engine_unit_assert.svh */
// Assertion macros for the LED cross-fade engine.
// Used by led_cross_fade_engine_unit; expects i_clk and i_rst_n in scope.
`ifndef LED_CROSS_FADE_ENGINE_UNIT_ASSERT_SVH
`define LED_CROSS_FADE_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define LCFE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define LCFE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lcfe_pkg.sv */
// Shared types and constants for the LED cross-fade engine.
// No dependencies; used by led_cross_fade_engine_unit.
package lcfe_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRD,
        ST_DIV,
        ST_SWR,
        ST_WALK,
        ST_ERD,
        ST_EOUT
    } t_state;

    // Request kinds
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_START    = 2'd1;
    localparam logic [1:0] OP_INVERT   = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // Animation modes
    localparam logic [1:0] MODE_NONE     = 2'd0;
    localparam logic [1:0] MODE_ON       = 2'd1;
    localparam logic [1:0] MODE_FADE     = 2'd2;
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    localparam logic [7:0] LEVEL_MAX   = 8'd255;
    localparam int         MAP_ENTRIES = 15;
    localparam int         IN_DATA_W   = 40;
    localparam int         OUT_DATA_W  = 32;

    // Wired position of each animation slot
    localparam logic [3:0] WIRING [MAP_ENTRIES] =
        '{4'd2, 4'd1, 4'd0, 4'd3, 4'd4, 4'd5, 4'd8, 4'd7, 4'd6,
          4'd9, 4'd10, 4'd11, 4'd14, 4'd13, 4'd12};

    // Slots past the wiring table map to their own index
    function automatic logic [5:0] map_pos(logic [5:0] slot);
        logic [5:0] pos;
        if (slot < 6'(MAP_ENTRIES)) begin
            pos = {2'b00, WIRING[slot[3:0]]};
        end else begin
            pos = slot;
        end
        return pos;
    endfunction

endpackage

/* sv/led_cross_fade_engine_unit.sv */
// Channel      | dir | payload
// s_axis       | in  | tuser: op; tdata: led, target_red/green/blue, mode, duration
// m_axis       | out | tdata: position, out_red/green/blue; tlast: last
// A start with a nonzero duration also runs the bit-serial divider
// (three channel lanes in parallel).
// A tick walks the slot memory (one read port, one slot per cycle), then
// emits every pixel, stalling while the output is not ready.
// Requests are taken only in the idle state; reset is synchronous, active low,
// and clears the valid bits of both memories, so no clearing pass is needed.
// Top level of the LED cross-fade engine; uses lcfe_pkg, lcfe_div and the
// assertion header led_cross_fade_engine_unit_assert.svh.
`include "led_cross_fade_engine_unit_assert.svh"

module led_cross_fade_engine_unit #(
    parameter int PIXEL_COUNT = 15,
    parameter int FRAC_BITS   = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // led[3:0], target_red[11:4], target_green[19:12], target_blue[27:20],
    // mode[29:28], duration[37:30], zero fill above
    input  logic [lcfe_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // op[1:0]
    input  logic [1:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // position[3:0], out_red[10:4], out_green[17:11], out_blue[24:18], zero fill
    output logic [lcfe_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast
);
    localparam int SW  = $clog2(PIXEL_COUNT);
    localparam int KW  = $clog2(PIXEL_COUNT + 1);
    localparam int CW  = 8 + FRAC_BITS;
    localparam int SDW = 9 + FRAC_BITS;
    localparam logic [CW-1:0] TOP = {8'hFF, {FRAC_BITS{1'b0}}};

    // Slot memory, one entry per animation slot
    logic [3*CW-1:0]  r_mem_cur   [PIXEL_COUNT];
    logic [3*SDW-1:0] r_mem_step  [PIXEL_COUNT];
    logic [23:0]      r_mem_tgt   [PIXEL_COUNT];
    logic [31:0]      r_mem_sf    [PIXEL_COUNT];
    logic [7:0]       r_mem_len   [PIXEL_COUNT];
    logic [1:0]       r_mem_mode  [PIXEL_COUNT];
    logic [PIXEL_COUNT-1:0] r_slot_vld;
    // Pixel memory, one entry per chain position
    logic [20:0]      r_mem_pix   [PIXEL_COUNT];
    logic [PIXEL_COUNT-1:0] r_pix_vld;

    // Registered read data
    logic [3*CW-1:0]  r_q_cur;
    logic [3*SDW-1:0] r_q_step;
    logic [23:0]      r_q_tgt;
    logic [31:0]      r_q_sf;
    logic [7:0]       r_q_len;
    logic [1:0]       r_q_mode;
    logic             r_q_vld;
    logic [20:0]      r_pq;
    logic             r_pq_vld;

    lcfe_pkg::t_state r_state, n_state;
    logic [31:0]      r_fc;
    logic [KW-1:0]    r_k;
    logic             r_pend;
    logic [KW-1:0]    r_pslot;

    // Captured request
    logic [1:0]  r_op;
    logic [3:0]  r_led;
    logic [23:0] r_in_tgt;
    logic [1:0]  r_in_mode;
    logic [7:0]  r_dur;
    logic [23:0] r_tgt;
    logic [2:0]  r_neg;

    logic             acc;
    logic [1:0]       in_op;
    logic [3:0]       in_led;
    logic             led_ok;

    logic             slot_rd;
    logic [SW-1:0]    slot_ra;
    logic             slot_we;
    logic [SW-1:0]    slot_wa;
    logic [3*CW-1:0]  w_cur;
    logic [3*SDW-1:0] w_step;
    logic [23:0]      w_tgt;
    logic [31:0]      w_sf;
    logic [7:0]       w_len;
    logic [1:0]       w_mode;
    logic             pix_we;
    logic [SW-1:0]    pix_wa;
    logic [20:0]      pix_wd;

    // Effective read data: a never-written entry reads as zero
    logic [3*CW-1:0]  e_cur;
    logic [3*SDW-1:0] e_step;
    logic [23:0]      e_tgt;
    logic [31:0]      e_sf;
    logic [7:0]       e_len;
    logic [1:0]       e_mode;

    logic             div_start;
    logic [CW-1:0]    div_mag [3];
    logic [CW-1:0]    div_quo [3];
    logic [2:0]       div_busy;
    logic [23:0]      s_tgt;
    logic [2:0]       s_neg;
    logic [3*SDW-1:0] s_step;
    logic [3*CW-1:0]  t_cur;
    logic [20:0]      t_pix;
    logic [5:0]       t_pos;

    assign in_op  = s_axis_tuser;
    assign in_led = s_axis_tdata[3:0];
    assign acc    = s_axis_tvalid && s_axis_tready;
    assign led_ok = 32'(in_led) < PIXEL_COUNT;

    assign e_cur  = r_q_vld ? r_q_cur  : '0;
    assign e_step = r_q_vld ? r_q_step : '0;
    assign e_tgt  = r_q_vld ? r_q_tgt  : '0;
    assign e_sf   = r_q_vld ? r_q_sf   : '0;
    assign e_len  = r_q_vld ? r_q_len  : '0;
    assign e_mode = r_q_vld ? r_q_mode : '0;

    // Start: targets, differences and divider operands
    always_comb begin
        logic [CW-1:0]  cur;
        logic [7:0]     tg;
        logic [SDW-1:0] diff;
        logic [SDW-1:0] mag;
        for (int c = 0; c < 3; c++) begin
            cur = e_cur[c*CW +: CW];
            if (r_op == lcfe_pkg::OP_START) begin
                tg = r_in_tgt[c*8 +: 8];
            end else begin
                tg = 8'(lcfe_pkg::LEVEL_MAX - cur[CW-1:FRAC_BITS]);
            end
            diff = {1'b0, tg, {FRAC_BITS{1'b0}}} - {1'b0, cur};
            mag  = diff[SDW-1] ? SDW'(-diff) : diff;
            s_tgt[c*8 +: 8] = tg;
            s_neg[c]        = diff[SDW-1];
            div_mag[c]      = mag[CW-1:0];
        end
    end

    // Signed steps from the quotients
    always_comb begin
        logic [SDW-1:0] q;
        for (int c = 0; c < 3; c++) begin
            q = {1'b0, div_quo[c]};
            if (r_dur == 8'd0) begin
                s_step[c*SDW +: SDW] = '0;
            end else begin
                s_step[c*SDW +: SDW] = r_neg[c] ? SDW'(-q) : q;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_div
            lcfe_div #(.CW(CW)) u_div (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_start (div_start),
                .i_num   (div_mag[g]),
                .i_den   (r_dur),
                .o_busy  (div_busy[g]),
                .o_quo   (div_quo[g])
            );
        end
    endgenerate

    // Tick: advance one slot and form its pixel
    always_comb begin
        logic [31:0]    elapsed;
        logic           in_fade;
        logic [CW-1:0]  cur;
        logic [SDW:0]   sum;
        logic [CW-1:0]  nv;
        logic [7:0]     lvl;
        elapsed = r_fc - e_sf;
        in_fade = elapsed <= {24'd0, e_len};
        t_cur   = e_cur;
        for (int c = 0; c < 3; c++) begin
            cur = e_cur[c*CW +: CW];
            sum = {2'b00, cur} + {e_step[c*SDW + SDW-1], e_step[c*SDW +: SDW]};
            if (!in_fade) begin
                nv = {e_tgt[c*8 +: 8], {FRAC_BITS{1'b0}}};
            end else if (sum[SDW]) begin
                nv = '0;
            end else if (sum[SDW-1:0] > {1'b0, TOP}) begin
                nv = TOP;
            end else begin
                nv = sum[CW-1:0];
            end
            if (e_mode == lcfe_pkg::MODE_ON) begin
                lvl = e_tgt[c*8 +: 8];
            end else begin
                lvl = nv[CW-1:FRAC_BITS];
            end
            t_cur[c*CW +: CW] = nv;
            t_pix[c*7 +: 7]   = lvl[7:1];
        end
        t_pos = lcfe_pkg::map_pos(6'(r_pslot));
    end

    // Next state, memory ports and handshake
    always_comb begin
        n_state   = r_state;
        slot_rd   = 1'b0;
        slot_ra   = SW'(in_led);
        slot_we   = 1'b0;
        slot_wa   = SW'(r_led);
        w_cur     = e_cur;
        w_step    = s_step;
        w_tgt     = r_tgt;
        w_sf      = r_fc;
        w_len     = r_dur;
        w_mode    = r_in_mode;
        pix_we    = 1'b0;
        pix_wa    = SW'(t_pos);
        pix_wd    = t_pix;
        div_start = 1'b0;
        unique case (r_state)
            lcfe_pkg::ST_IDLE: begin
                if (acc) begin
                    priority if (in_op == lcfe_pkg::OP_TICK) begin
                        n_state = lcfe_pkg::ST_WALK;
                    end else if ((in_op == lcfe_pkg::OP_START ||
                                  in_op == lcfe_pkg::OP_INVERT) && led_ok) begin
                        slot_rd = 1'b1;
                        n_state = lcfe_pkg::ST_SRD;
                    end else begin
                        n_state = lcfe_pkg::ST_IDLE;
                    end
                end
            end
            lcfe_pkg::ST_SRD: begin
                div_start = r_dur != 8'd0;
                n_state   = (r_dur != 8'd0) ? lcfe_pkg::ST_DIV : lcfe_pkg::ST_SWR;
            end
            lcfe_pkg::ST_DIV: begin
                if (div_busy == 3'b000) begin
                    n_state = lcfe_pkg::ST_SWR;
                end
            end
            lcfe_pkg::ST_SWR: begin
                slot_we = 1'b1;
                n_state = lcfe_pkg::ST_IDLE;
            end
            lcfe_pkg::ST_WALK: begin
                slot_rd = 32'(r_k) < PIXEL_COUNT;
                slot_ra = SW'(r_k);
                if (r_pend) begin
                    slot_wa = SW'(r_pslot);
                    w_cur   = t_cur;
                    w_step  = e_step;
                    w_tgt   = e_tgt;
                    w_sf    = e_sf;
                    w_len   = e_len;
                    w_mode  = e_mode;
                    slot_we = e_mode == lcfe_pkg::MODE_FADE;
                    pix_we  = (e_mode == lcfe_pkg::MODE_FADE ||
                               e_mode == lcfe_pkg::MODE_ON) &&
                              (32'(t_pos) < PIXEL_COUNT);
                end
                if (!slot_rd && !r_pend) begin
                    n_state = lcfe_pkg::ST_ERD;
                end
            end
            lcfe_pkg::ST_ERD: begin
                n_state = lcfe_pkg::ST_EOUT;
            end
            lcfe_pkg::ST_EOUT: begin
                if (m_axis_tready) begin
                    n_state = (32'(r_k) == PIXEL_COUNT - 1) ? lcfe_pkg::ST_IDLE
                                                           : lcfe_pkg::ST_ERD;
                end
            end
            default: begin
                n_state = lcfe_pkg::ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcfe_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Frame count, walk counter and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc       <= '0;
            r_k        <= '0;
            r_pend     <= 1'b0;
            r_slot_vld <= '0;
            r_pix_vld  <= '0;
        end else begin
            if (acc && in_op == lcfe_pkg::OP_TICK) begin
                r_fc   <= r_fc + 32'd1;
                r_k    <= '0;
                r_pend <= 1'b0;
            end
            // Hold the count past the table until the last slot is written back
            if (r_state == lcfe_pkg::ST_WALK) begin
                r_pend <= slot_rd;
                if (slot_rd) begin
                    r_k <= r_k + 1'b1;
                end else if (!r_pend) begin
                    r_k <= '0;
                end
            end
            if (r_state == lcfe_pkg::ST_EOUT && m_axis_tready) begin
                r_k <= r_k + 1'b1;
            end
            if (slot_we) begin
                r_slot_vld[slot_wa] <= 1'b1;
            end
            if (pix_we) begin
                r_pix_vld[pix_wa] <= 1'b1;
            end
        end
    end

    // Capture request fields and start results
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op      <= in_op;
            r_led     <= in_led;
            r_in_tgt  <= s_axis_tdata[27:4];
            r_in_mode <= s_axis_tdata[29:28];
            r_dur     <= s_axis_tdata[37:30];
        end
        if (r_state == lcfe_pkg::ST_SRD) begin
            r_tgt <= s_tgt;
            r_neg <= s_neg;
        end
        r_pslot <= r_k;
    end

    // Slot memory: one read, one write per cycle
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_mem_cur[slot_wa]  <= w_cur;
            r_mem_step[slot_wa] <= w_step;
            r_mem_tgt[slot_wa]  <= w_tgt;
            r_mem_sf[slot_wa]   <= w_sf;
            r_mem_len[slot_wa]  <= w_len;
            r_mem_mode[slot_wa] <= w_mode;
        end
        if (slot_rd) begin
            r_q_cur  <= r_mem_cur[slot_ra];
            r_q_step <= r_mem_step[slot_ra];
            r_q_tgt  <= r_mem_tgt[slot_ra];
            r_q_sf   <= r_mem_sf[slot_ra];
            r_q_len  <= r_mem_len[slot_ra];
            r_q_mode <= r_mem_mode[slot_ra];
            r_q_vld  <= r_slot_vld[slot_ra];
        end
    end

    // Pixel memory: written by the walk, read by the emit loop
    always_ff @(posedge i_clk) begin
        if (pix_we) begin
            r_mem_pix[pix_wa] <= pix_wd;
        end
        if (r_state == lcfe_pkg::ST_ERD) begin
            r_pq     <= r_mem_pix[SW'(r_k)];
            r_pq_vld <= r_pix_vld[SW'(r_k)];
        end
    end

    assign s_axis_tready = r_state == lcfe_pkg::ST_IDLE;
    assign m_axis_tvalid = r_state == lcfe_pkg::ST_EOUT;
    assign m_axis_tlast  = 32'(r_k) == PIXEL_COUNT - 1;
    assign m_axis_tdata  = {7'd0, (r_pq_vld ? r_pq : 21'd0), 4'(r_k)};

    `LCFE_ASSERT_IMP(a_no_overlap, m_axis_tvalid, !s_axis_tready, "request taken while emitting")
    `LCFE_ASSERT_NXT(a_tick_walk, acc && in_op == lcfe_pkg::OP_TICK, r_state == lcfe_pkg::ST_WALK, "tick did not start walk")
    `LCFE_ASSERT_IMP(a_div_state, div_busy != 3'b000, r_state == lcfe_pkg::ST_DIV, "divider busy outside divide")
    `LCFE_ASSERT_IMP(a_walk_wr, slot_we && r_state == lcfe_pkg::ST_WALK, slot_wa != slot_ra || !slot_rd, "walk write hits read slot")

endmodule

/* sv/lcfe_div.sv */
// Restoring divider lane: unsigned magnitude by 8-bit divisor, one bit a cycle.
// Depends on nothing; instantiated three times by the top level.
module lcfe_div #(
    parameter int CW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [CW-1:0] i_num,
    input  logic [7:0]    i_den,
    output logic          o_busy,
    output logic [CW-1:0] o_quo
);
    localparam int CNT_W = $clog2(CW + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [7:0]       r_rem;
    logic [CW-1:0]    r_quo;
    logic [7:0]       r_den;
    logic [8:0]       trial;
    logic             fits;

    // Shift in the next numerator bit and try the subtraction
    assign trial = {r_rem, r_quo[CW-1]};
    assign fits  = trial >= {1'b0, r_den};

    // Control: count down one bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(CW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? 8'(trial - {1'b0, r_den}) : trial[7:0];
            r_quo <= {r_quo[CW-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule
